// ===== rtl/core/mi4_pkg.sv =====
`timescale 1ns / 1ps

package mi4_pkg;

  localparam int N_ENTRIES = 16;
  localparam int IDX_W     = 4;
  localparam int THR_W     = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1;

  typedef logic [1:0] sub_t;

  // n-th of the three row/col numbers that remain once 'skip' is removed
  function automatic sub_t other_idx(input sub_t skip, input sub_t n);
    other_idx = (n < skip) ? n : sub_t'(n + 2'd1);
  endfunction

  // (n + 1) mod 3 for n in 0..2
  function automatic sub_t inc3(input sub_t n);
    inc3 = (n == 2'd2) ? 2'd0 : sub_t'(n + 2'd1);
  endfunction

endpackage

// ===== rtl/core/mi4_stream_if.sv =====
`timescale 1ns / 1ps

interface mi4_entry_if #(parameter int ENTRY_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [ENTRY_WIDTH-1:0] entry_value;

  modport source(output valid, output entry_value, input ready);
  modport sink(input valid, input entry_value, output ready);
endinterface

interface mi4_result_if #(parameter int ENTRY_WIDTH = 32) ();
  logic                           valid;
  logic                           ready;
  logic signed [ENTRY_WIDTH-1:0]  result_value;
  logic [mi4_pkg::IDX_W-1:0]      result_index;
  logic                           singular;
  logic                           last;

  modport source(output valid, output result_value, output result_index,
                 output singular, output last, input ready);
  modport sink(input valid, input result_value, input result_index,
               input singular, input last, output ready);
endinterface

// ===== rtl/core/mi4_mul.sv =====
`timescale 1ns / 1ps

// Shift-add multiplier: wide signed x times a signed entry, one bit per cycle.
module mi4_mul #(
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [4*ENTRY_WIDTH+3:0] x_in,
  input  logic [ENTRY_WIDTH-1:0]          e_in,
  output logic                            done,
  output logic signed [4*ENTRY_WIDTH+3:0] p
);
  localparam int W  = ENTRY_WIDTH;
  localparam int BW = 4 * W + 4;
  localparam int CW = $clog2(W);

  logic signed [BW-1:0] x;
  logic [W-1:0]         e;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 first;
  logic signed [BW-1:0] addend;

  // msb of the entry carries negative weight
  always_comb begin
    if (!e[W-1]) begin
      addend = '0;
    end else if (first) begin
      addend = -x;
    end else begin
      addend = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x     <= x_in;
        e     <= e_in;
        p     <= '0;
        cnt   <= CW'(W - 1);
        first <= 1'b1;
        busy  <= 1'b1;
      end else if (busy) begin
        p     <= (p <<< 1) + addend;
        e     <= e << 1;
        first <= 1'b0;
        cnt   <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/mi4_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, ENTRY_WIDTH+1 quotient bits, flags quotients that need more.
module mi4_div #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [4*ENTRY_WIDTH+2*FRAC_BITS+5:0]      num,
  input  logic [4*ENTRY_WIDTH+4:0]                  den,
  output logic                                      done,
  output logic                                      ovf,
  output logic [ENTRY_WIDTH:0]                      q
);
  localparam int W  = ENTRY_WIDTH;
  localparam int BW = 4 * W + 4;
  localparam int DW = BW + 1;
  localparam int NW = BW + 2 * FRAC_BITS + 2;
  localparam int QW = W + 1;
  localparam int HW = NW - QW;
  localparam int XW = (HW > DW) ? HW : DW;
  localparam int CW = $clog2(QW);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [QW-1:0] nlo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [XW-1:0] hi_x;
  logic [DW:0]   sh;
  logic          fits;

  assign hi_x = XW'(num[NW-1:QW]);
  assign sh   = {rem, nlo[QW-1]};
  assign fits = sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dreg <= den;
        rem  <= hi_x[DW-1:0];
        ovf  <= hi_x >= XW'(den);
        nlo  <= num[QW-1:0];
        q    <= '0;
        cnt  <= CW'(QW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? DW'(sh - {1'b0, dreg}) : sh[DW-1:0];
        q    <= {q[QW-2:0], fits};
        nlo  <= nlo << 1;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/matrix_inverse_4x4_top.sv =====
`timescale 1ns / 1ps

// 4x4 matrix inverse by cofactors, signed fixed point with FRAC_BITS fraction bits.
// entry_ch: sixteen items, entries 0..15 in order, one per cycle while ready is high.
// result_ch: sixteen inverse entries in input order (last on index 15), or a
//   single item flagged singular (value 0, index 0, last set) when |det| is zero
//   or below singular_threshold (written through cfg_we / cfg_wdata).
// Flow: load the sixteen entries, then cofactors and determinant on one shift-add
//   multiplier, 148 multiplies in all; then one restoring division per result.
// One matrix at a time; the pace is set by the bit-serial multiplier and divider.
// entry_ch.ready is high only while loading; no item is taken while a matrix is
//   being worked or its results are out.
// The threshold in force when the sixteenth entry is taken is the one applied.
// A stalled receiver holds the result register and the sequencer waits.
// Reset: load count, sequencer and valid clear; threshold returns to 1.
module matrix_inverse_4x4_top #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  mi4_entry_if.sink                   entry_ch,
  mi4_result_if.source                result_ch,
  input  logic                        cfg_we,
  input  logic [mi4_pkg::THR_W-1:0]   cfg_wdata
);
  localparam int W  = ENTRY_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int BW = 4 * W + 4;             // holds det exactly with headroom
  localparam int DW = BW + 1;
  localparam int NW = BW + 2 * F + 2;
  localparam int QW = W + 1;
  localparam int LW = ((BW > mi4_pkg::THR_W + 3 * F) ? BW : mi4_pkg::THR_W + 3 * F) + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_FX, S_FE, S_MS, S_MW, S_CW, S_CHK1, S_CHK2,
    S_DR, S_DA, S_DS, S_DW, S_OUT
  } state_t;

  // what a multiply feeds: 2x2 product, 2x2 difference, cofactor term, det term
  typedef enum logic [1:0] {PH_PROD, PH_DIFF, PH_ACC, PH_DET} phase_t;

  state_t state;
  phase_t ph;

  logic [mi4_pkg::THR_W-1:0] thr;
  logic [mi4_pkg::THR_W-1:0] thr_used;
  logic [mi4_pkg::IDX_W-1:0] load_cnt;
  logic [mi4_pkg::IDX_W-1:0] k;
  mi4_pkg::sub_t             t;

  logic [W-1:0]  mat_mem [mi4_pkg::N_ENTRIES];
  logic [W-1:0]  rd_data;
  logic [mi4_pkg::IDX_W-1:0] rd_addr;

  logic signed [BW-1:0] cof_mem [mi4_pkg::N_ENTRIES];
  logic signed [BW-1:0] cof_rd;

  logic signed [BW-1:0] x_reg, m_reg, d_reg, acc, det;
  logic [BW-1:0]        dmag, cabs;
  logic                 dneg, cneg;

  logic                 mul_start, mul_done;
  logic signed [BW-1:0] mul_p;
  logic                 div_start, div_done, div_ovf;
  logic [QW-1:0]        div_q;
  logic [NW-1:0]        div_num;

  // cofactor k: leave out row j = k[1:0] and column i = k[3:2]
  mi4_pkg::sub_t ci, rj, r0, r1, r2, ct, c1, c2;
  logic          cof_neg;
  logic [mi4_pkg::IDX_W-1:0] a_addr, b_addr, c_addr, d_addr, f_addr;

  always_comb begin
    ci = k[3:2];
    rj = k[1:0];
    r0 = mi4_pkg::other_idx(rj, 2'd0);
    r1 = mi4_pkg::other_idx(rj, 2'd1);
    r2 = mi4_pkg::other_idx(rj, 2'd2);
    ct = mi4_pkg::other_idx(ci, t);
    c1 = mi4_pkg::other_idx(ci, mi4_pkg::inc3(t));
    c2 = mi4_pkg::other_idx(ci, mi4_pkg::inc3(mi4_pkg::inc3(t)));
    a_addr = {r0, ct};
    b_addr = {r1, c1};
    c_addr = {r2, c2};
    d_addr = {r1, c2};
    f_addr = {r2, c1};
    cof_neg = ci[0] ^ rj[0];
  end

  // store read address: x operand in S_FX, multiplier entry in S_FE
  always_comb begin
    rd_addr = b_addr;
    if (state == S_FX) begin
      rd_addr = (ph == PH_DIFF) ? d_addr : b_addr;
    end else begin
      case (ph)
        PH_PROD: rd_addr = c_addr;
        PH_DIFF: rd_addr = f_addr;
        PH_ACC:  rd_addr = a_addr;
        default: rd_addr = {2'b00, k[3:2]};
      endcase
    end
  end

  assign entry_ch.ready = (state == S_LOAD);
  assign mul_start      = (state == S_MS);
  assign div_start      = (state == S_DS);
  assign div_num        = (NW'(cabs) << (2 * F + 1)) + NW'(dmag);

  always_ff @(posedge clk) begin
    if (entry_ch.valid && entry_ch.ready) begin
      mat_mem[load_cnt] <= entry_ch.entry_value;
    end
    rd_data <= mat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_CW) begin
      cof_mem[k] <= acc;
    end
    cof_rd <= cof_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= mi4_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  mi4_mul #(.ENTRY_WIDTH(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x_in  (x_reg),
    .e_in  (rd_data),
    .done  (mul_done),
    .p     (mul_p)
  );

  mi4_div #(.ENTRY_WIDTH(W), .FRAC_BITS(F)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   ({dmag, 1'b0}),
    .done  (div_done),
    .ovf   (div_ovf),
    .q     (div_q)
  );

  // rounding is in the numerator; here saturate and restore the sign
  logic          qneg;
  logic [QW-1:0] qsat, qv, qs;
  logic [LW-1:0] lim;

  always_comb begin
    qneg = cneg ^ dneg;
    qsat = qneg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    qv   = (div_ovf || (div_q > qsat)) ? qsat : div_q;
    qs   = qneg ? (QW'(0) - qv) : qv;
    lim  = LW'(thr_used) << (3 * F);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      load_cnt        <= '0;
      result_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (entry_ch.valid) begin
            load_cnt <= load_cnt + 1'b1;
            if (load_cnt == 4'(mi4_pkg::N_ENTRIES - 1)) begin
              thr_used <= thr;
              k        <= '0;
              t        <= '0;
              ph       <= PH_PROD;
              det      <= '0;
              state    <= S_FX;
            end
          end
        end
        S_FX: state <= S_FE;
        S_FE: begin
          case (ph)
            PH_ACC:  x_reg <= d_reg;
            PH_DET:  x_reg <= acc;
            default: x_reg <= {{(BW - W){rd_data[W-1]}}, rd_data};
          endcase
          state <= S_MS;
        end
        S_MS: state <= S_MW;
        S_MW: begin
          if (mul_done) begin
            case (ph)
              PH_PROD: begin
                m_reg <= mul_p;
                if (t == 2'd0) acc <= '0;
                ph    <= PH_DIFF;
                state <= S_FX;
              end
              PH_DIFF: begin
                d_reg <= m_reg - mul_p;
                ph    <= PH_ACC;
                state <= S_FX;
              end
              PH_ACC: begin
                acc <= cof_neg ? (acc - mul_p) : (acc + mul_p);
                if (t == 2'd2) begin
                  state <= S_CW;
                end else begin
                  t     <= t + 2'd1;
                  ph    <= PH_PROD;
                  state <= S_FX;
                end
              end
              default: begin
                // det accumulates along the first row against cofactors 0,4,8,12
                det   <= det + mul_p;
                k     <= k + 1'b1;
                t     <= '0;
                ph    <= PH_PROD;
                state <= S_FX;
              end
            endcase
          end
        end
        S_CW: begin
          if (k[1:0] == 2'd0) begin
            ph    <= PH_DET;
            state <= S_FX;
          end else if (k == 4'(mi4_pkg::N_ENTRIES - 1)) begin
            state <= S_CHK1;
          end else begin
            k     <= k + 1'b1;
            t     <= '0;
            ph    <= PH_PROD;
            state <= S_FX;
          end
        end
        S_CHK1: begin
          dneg  <= det[BW-1];
          dmag  <= det[BW-1] ? BW'(-det) : det;
          state <= S_CHK2;
        end
        S_CHK2: begin
          if ((dmag == '0) || (LW'(dmag) < lim)) begin
            result_ch.result_value <= '0;
            result_ch.result_index <= '0;
            result_ch.singular     <= 1'b1;
            result_ch.last         <= 1'b1;
            result_ch.valid        <= 1'b1;
            state                  <= S_OUT;
          end else begin
            k     <= '0;
            state <= S_DR;
          end
        end
        S_DR: state <= S_DA;
        S_DA: begin
          cneg  <= cof_rd[BW-1];
          cabs  <= cof_rd[BW-1] ? BW'(-cof_rd) : cof_rd;
          state <= S_DS;
        end
        S_DS: state <= S_DW;
        S_DW: begin
          if (div_done) begin
            result_ch.result_value <= qs[W-1:0];
            result_ch.result_index <= k;
            result_ch.singular     <= 1'b0;
            result_ch.last         <= (k == 4'(mi4_pkg::N_ENTRIES - 1));
            result_ch.valid        <= 1'b1;
            state                  <= S_OUT;
          end
        end
        S_OUT: begin
          if (result_ch.ready) begin
            result_ch.valid <= 1'b0;
            if (result_ch.last) begin
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_DR;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== rtl/core/mi4_chk.sv =====
`timescale 1ns / 1ps

module mi4_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [mi4_pkg::IDX_W-1:0] out_index,
  input logic                      out_singular,
  input logic                      out_last
);
  // loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_singular_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_singular |-> out_last && (out_index == '0))
    else $error("singular item without last or with nonzero index");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last && !out_singular |-> out_index == 4'd15)
    else $error("last flag on an index other than 15");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
endmodule

bind matrix_inverse_4x4_top mi4_chk u_mi4_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (entry_ch.ready),
  .out_valid    (result_ch.valid),
  .out_ready    (result_ch.ready),
  .out_index    (result_ch.result_index),
  .out_singular (result_ch.singular),
  .out_last     (result_ch.last)
);
